// ===== design/crrp_pkg.sv =====
`default_nettype none
package crrp_pkg;

    localparam int CHAR_W    = 8;
    localparam int ROW_OUT_W = 31;
    localparam int COL_OUT_W = 24;
    localparam int EXT_W     = 32;

    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0] CH_COLON   = 8'h3A;

    // One parsed range, as handed to the result channel.
    typedef struct packed {
        logic                 valid_res;
        logic [ROW_OUT_W-1:0] top_row;
        logic [COL_OUT_W-1:0] top_column;
        logic [ROW_OUT_W-1:0] bottom_row;
        logic [COL_OUT_W-1:0] bottom_column;
    } crrp_result_t;

endpackage
`default_nettype wire

// ===== design/crrp_in_if.sv =====
`default_nettype none
interface crrp_in_if;
    import crrp_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              is_last;

    modport source (output valid, output char_code, output is_last, input ready);
    modport sink   (input valid, input char_code, input is_last, output ready);

endinterface
`default_nettype wire

// ===== design/crrp_out_if.sv =====
`default_nettype none
interface crrp_out_if;
    import crrp_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 valid_res;
    logic [ROW_OUT_W-1:0] top_row;
    logic [COL_OUT_W-1:0] top_column;
    logic [ROW_OUT_W-1:0] bottom_row;
    logic [COL_OUT_W-1:0] bottom_column;

    modport source (output valid, output valid_res, output top_row, output top_column,
                    output bottom_row, output bottom_column, input ready);
    modport sink   (input valid, input valid_res, input top_row, input top_column,
                    input bottom_row, input bottom_column, output ready);

endinterface
`default_nettype wire

// ===== design/crrp_core.sv =====
`default_nettype none
module crrp_core #(
    parameter int COLUMN_BITS = 24,
    parameter int ROW_BITS    = 31
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       fire,
    input  wire logic [crrp_pkg::CHAR_W-1:0] char_code,
    input  wire logic                       is_last,
    output crrp_pkg::crrp_result_t          result
);
    import crrp_pkg::*;

    localparam int COL_PROD_W = COLUMN_BITS + 5;
    localparam int ROW_PROD_W = ROW_BITS + 4;

    logic                   second_half_reg, second_half_next;
    logic                   in_digits_reg, in_digits_next;
    logic                   bad_flag_reg, bad_flag_next;
    logic [COLUMN_BITS-1:0] column_accum_reg, column_accum_next;
    logic [ROW_BITS-1:0]    row_accum_reg, row_accum_next;
    logic [COLUMN_BITS-1:0] start_column_reg, start_column_next;
    logic [ROW_BITS-1:0]    start_row_reg, start_row_next;

    logic                   is_upper, is_lower, is_digit, is_colon;
    logic [CHAR_W-1:0]      letter_ofs, digit_ofs;
    logic [4:0]             letter_val;
    logic [COL_PROD_W-1:0]  col_ext, col_prod;
    logic [ROW_PROD_W-1:0]  row_ext, row_prod;
    logic                   bad_step;
    logic                   bad_final;
    logic [EXT_W-1:0]       top_row_ext, bot_row_ext, top_col_ext, bot_col_ext;

    assign is_upper   = (char_code >= CH_UPPER_A) && (char_code <= CH_UPPER_Z);
    assign is_lower   = (char_code >= CH_LOWER_A) && (char_code <= CH_LOWER_Z);
    assign is_digit   = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    assign is_colon   = (char_code == CH_COLON);
    assign letter_ofs = char_code - (is_lower ? CH_LOWER_A : CH_UPPER_A);
    assign letter_val = letter_ofs[4:0] + 5'd1;
    assign digit_ofs  = char_code - CH_ZERO;

    // times 26 and times 10 as shift-adds
    assign col_ext  = COL_PROD_W'(column_accum_reg);
    assign col_prod = (col_ext << 4) + (col_ext << 3) + (col_ext << 1)
                    + COL_PROD_W'(letter_val);
    assign row_ext  = ROW_PROD_W'(row_accum_reg);
    assign row_prod = (row_ext << 3) + (row_ext << 1) + ROW_PROD_W'(digit_ofs[3:0]);

    always_comb
    begin
        second_half_next  = second_half_reg;
        in_digits_next    = in_digits_reg;
        column_accum_next = column_accum_reg;
        row_accum_next    = row_accum_reg;
        start_column_next = start_column_reg;
        start_row_next    = start_row_reg;
        bad_step          = bad_flag_reg;

        if (is_upper || is_lower)
        begin
            if (in_digits_reg || (col_prod[COL_PROD_W-1:COLUMN_BITS] != '0))
            begin
                bad_step = 1'b1;
            end
            column_accum_next = col_prod[COLUMN_BITS-1:0];
        end
        else if (is_digit)
        begin
            in_digits_next = 1'b1;
            if (row_prod[ROW_PROD_W-1:ROW_BITS] != '0)
            begin
                bad_step = 1'b1;
            end
            row_accum_next = row_prod[ROW_BITS-1:0];
        end
        else if (is_colon)
        begin
            if (second_half_reg)
            begin
                bad_step = 1'b1;
            end
            else
            begin
                if ((column_accum_reg == '0) || (row_accum_reg == '0))
                begin
                    bad_step = 1'b1;
                end
                start_row_next    = row_accum_reg;
                start_column_next = column_accum_reg;
                row_accum_next    = '0;
                column_accum_next = '0;
                in_digits_next    = 1'b0;
                second_half_next  = 1'b1;
            end
        end
        else
        begin
            bad_step = 1'b1;
        end
        bad_flag_next = bad_step;

        // closing checks on the state as it stands after this char
        bad_final = bad_step || !second_half_next
                 || (column_accum_next == '0) || (row_accum_next == '0)
                 || (start_row_next > row_accum_next)
                 || (start_column_next > column_accum_next);

        // end of reference: drop back to the start state
        if (is_last)
        begin
            second_half_next  = 1'b0;
            in_digits_next    = 1'b0;
            bad_flag_next     = 1'b0;
            column_accum_next = '0;
            row_accum_next    = '0;
            start_column_next = '0;
            start_row_next    = '0;
        end
    end

    assign top_row_ext = EXT_W'(start_row_reg);
    assign top_col_ext = EXT_W'(start_column_reg);
    assign bot_row_ext = EXT_W'(row_accum_reg);
    assign bot_col_ext = EXT_W'(column_accum_reg);

    // result fields come from the post-char values, before the return to start
    always_comb
    begin
        result = '0;
        if (!bad_final)
        begin
            result.valid_res     = 1'b1;
            result.top_row       = (is_colon && !second_half_reg)
                                 ? ROW_OUT_W'(EXT_W'(row_accum_reg))
                                 : top_row_ext[ROW_OUT_W-1:0];
            result.top_column    = (is_colon && !second_half_reg)
                                 ? COL_OUT_W'(EXT_W'(column_accum_reg))
                                 : top_col_ext[COL_OUT_W-1:0];
            result.bottom_row    = (is_digit || is_colon)
                                 ? ROW_OUT_W'(EXT_W'(row_prod[ROW_BITS-1:0]))
                                 : bot_row_ext[ROW_OUT_W-1:0];
            result.bottom_column = (is_upper || is_lower)
                                 ? COL_OUT_W'(EXT_W'(col_prod[COLUMN_BITS-1:0]))
                                 : bot_col_ext[COL_OUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            second_half_reg  <= 1'b0;
            in_digits_reg    <= 1'b0;
            bad_flag_reg     <= 1'b0;
            column_accum_reg <= '0;
            row_accum_reg    <= '0;
            start_column_reg <= '0;
            start_row_reg    <= '0;
        end
        else if (fire)
        begin
            second_half_reg  <= second_half_next;
            in_digits_reg    <= in_digits_next;
            bad_flag_reg     <= bad_flag_next;
            column_accum_reg <= column_accum_next;
            row_accum_reg    <= row_accum_next;
            start_column_reg <= start_column_next;
            start_row_reg    <= start_row_next;
        end
    end

endmodule
`default_nettype wire

// ===== design/cell_range_reference_parser_unit.sv =====
//  channel   dir  iface        payload
//  chars     in   crrp_in_if   char_code[7:0], is_last
//  results   out  crrp_out_if  valid_res, top_row[30:0], top_column[23:0],
//                              bottom_row[30:0], bottom_column[23:0]
//
//  One char per cycle, sustained unless a last char waits on a stalled result.
//  A char is held in the input register; the parser state updates as it
//  leaves, and the last char of a reference loads the result register from
//  there. The combinational step (times-26/times-10 shift-add plus the
//  corner compare) sets this rate. Reset clears all parser state and both
//  valid flags. A stalled result holds only a last char in the input
//  register; other chars keep flowing.
`default_nettype none
module cell_range_reference_parser_unit #(
    parameter int COLUMN_BITS = 24,
    parameter int ROW_BITS    = 31
) (
    input wire logic   clk,
    input wire logic   rst_n,
    crrp_in_if.sink    chars,
    crrp_out_if.source results
);
    import crrp_pkg::*;

    logic              in_valid_reg, in_valid_next;
    logic [CHAR_W-1:0] in_char_reg;
    logic              in_last_reg;
    logic              out_valid_reg, out_valid_next;
    crrp_result_t      out_res_reg;
    crrp_result_t      step_res;
    logic              out_free;
    logic              step_fire;
    logic              accept;

    // the output register frees up when empty or being taken
    assign out_free  = !out_valid_reg || results.ready;
    // a plain char always advances; a last char needs room for its result
    assign step_fire = in_valid_reg && (!in_last_reg || out_free);
    assign chars.ready = !in_valid_reg || step_fire;
    assign accept      = chars.valid && chars.ready;

    crrp_core #(
        .COLUMN_BITS (COLUMN_BITS),
        .ROW_BITS    (ROW_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (step_fire),
        .char_code (in_char_reg),
        .is_last   (in_last_reg),
        .result    (step_res)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (step_fire)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (step_fire && in_last_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload: hold unless loaded
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_char_reg <= chars.char_code;
            in_last_reg <= chars.is_last;
        end
        if (step_fire && in_last_reg)
        begin
            out_res_reg <= step_res;
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.valid_res     = out_res_reg.valid_res;
    assign results.top_row       = out_res_reg.top_row;
    assign results.top_column    = out_res_reg.top_column;
    assign results.bottom_row    = out_res_reg.bottom_row;
    assign results.bottom_column = out_res_reg.bottom_column;

    a_valid_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_res_reg.valid_res) |->
            (out_res_reg.top_row != '0) && (out_res_reg.top_column != '0)
            && (out_res_reg.top_row <= out_res_reg.bottom_row)
            && (out_res_reg.top_column <= out_res_reg.bottom_column))
        else $error("valid range with empty or misordered corners");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_res_reg.valid_res) |->
            (out_res_reg.top_row == '0) && (out_res_reg.top_column == '0)
            && (out_res_reg.bottom_row == '0) && (out_res_reg.bottom_column == '0))
        else $error("invalid range carries nonzero corners");

    a_hold_char: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !step_fire) |=> (in_valid_reg && $stable(in_char_reg)
            && $stable(in_last_reg)))
        else $error("held char lost or changed");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !chars.ready |-> (in_valid_reg && in_last_reg && out_valid_reg && !results.ready))
        else $error("input stalled without a blocked result");

endmodule
`default_nettype wire
